/* rtl/core/bmcg_pkg.sv */
// shared types, constants and the output alphabet for the binary mlp character generator
// no dependencies
package bmcg_pkg;

	localparam int MaxGenerated = 15;
	localparam int ContextLimit = 256;
	localparam int NumFeat      = 96;
	localparam int NumHid       = 64;
	localparam int NumOut       = 45;

	localparam logic [10:0] ImgSize = 11'd1597;
	localparam logic [10:0] L2Base  = 11'd768;
	localparam logic [10:0] B1Base  = 11'd1488;
	localparam logic [10:0] B2Base  = 11'd1552;
	localparam logic [5:0]  StopIdx = 6'd44;

	localparam logic [1:0] CmdWeight = 2'd0;
	localparam logic [1:0] CmdPrompt = 2'd1;
	localparam logic [1:0] CmdGen    = 2'd2;

	typedef struct packed {
		logic       shift;
		logic       clear;
		logic       set_pos;
		logic       pos_en;
		logic [6:0] pos_a;
		logic [6:0] pos_b;
		logic       bump_t_en;
		logic [5:0] bump_t_idx;
		logic       bump_c_en;
		logic [3:0] bump_c_idx;
	} feat_ctl_t;

	typedef struct packed {
		logic load;
		logic rot;
	} hid_ctl_t;

	function automatic logic [7:0] alpha_char(input logic [5:0] idx);
		logic [7:0] r;
		r = 8'h00;
		if (idx == 6'd0) r = 8'h20;
		else if (idx <= 6'd26) r = 8'h60 + {2'b00, idx};
		else if (idx <= 6'd36) r = 8'h30 + {2'b00, idx} - 8'd27;
		else begin
			case (idx)
				6'd37: r = 8'h2E;
				6'd38: r = 8'h2D;
				6'd39: r = 8'h2C;
				6'd40: r = 8'h21;
				6'd41: r = 8'h3F;
				6'd42: r = 8'h27;
				6'd43: r = 8'h2F;
				default: r = 8'h00;
			endcase
		end
		return r;
	endfunction

endpackage

/* rtl/core/binary_mlp_char_generator_core.sv */
// binary mlp character generator: weight memory, sequencer and the two cell chains
// depends on bmcg_pkg, bmcg_feat_cell, bmcg_hid_cell
// weight and prompt words are taken in the idle state; a generate word runs up to 15 steps,
// each an init state, 64 rows over the feature chain and 45 rows over the hidden chain (per
// row a bias read, a base and the accumulate states) and a decide state, plus output waits
// reset: asynchronous, clears counts, context, sequencer and output valid; weights undefined
module binary_mlp_char_generator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // weight_addr, byte_value, zero fill
	input  logic [1:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_char
	output logic        m_tuser,   // is_empty
	output logic        m_tlast
);
	import bmcg_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_INIT = 4'd1;
	localparam logic [3:0] S_L1RB = 4'd2;
	localparam logic [3:0] S_L1B  = 4'd3;
	localparam logic [3:0] S_L1A  = 4'd4;
	localparam logic [3:0] S_L2RB = 4'd5;
	localparam logic [3:0] S_L2B  = 4'd6;
	localparam logic [3:0] S_L2A  = 4'd7;
	localparam logic [3:0] S_DEC  = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;

	logic [3:0]  state_q;
	logic [7:0]  wmem [1597];
	logic [7:0]  rdata_q;
	logic [10:0] raddr;
	logic [6:0]  row_q;
	logic [3:0]  col_q;
	logic [3:0]  prod_q;
	logic        grew_q, gt_q, pend_v_q;
	logic [7:0]  pend_q, p0_q, p1_q;
	logic [8:0]  len_q;
	logic signed [15:0] acc1_q;
	logic signed [17:0] acc2_q, best_q;
	logic [5:0]  best_idx_q;
	logic        out_v_q, out_empty_q, out_last_q;
	logic [7:0]  out_char_q;

	logic [7:0]  feat_q [NumFeat];
	logic [7:0]  hid_q [NumHid];
	feat_ctl_t   fctl;
	hid_ctl_t    hctl;

	logic        acc_in, out_free, push_en, out_load;
	logic [7:0]  push_c, in_c, hval, dec_c;
	logic [10:0] in_addr;
	logic [7:0]  in_val;
	logic [11:0] tri_sum;
	logic signed [11:0] sum1, sum2;
	logic signed [15:0] tot1;
	logic signed [17:0] tot2;

	assign s_tready = (state_q == S_IDLE);
	assign acc_in   = s_tvalid && s_tready;
	assign in_addr  = s_tdata[10:0];
	assign in_val   = s_tdata[18:11];
	assign out_free = !out_v_q || m_tready;
	assign dec_c    = alpha_char(best_idx_q);
	assign in_c     = (in_val >= 8'h41 && in_val <= 8'h5A) ? in_val + 8'd32 : in_val;
	assign out_load = (state_q == S_DEC && best_idx_q != StopIdx && pend_v_q && out_free)
		|| (state_q == S_FIN && out_free);

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_char_q;
	assign m_tuser  = out_empty_q;
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk) begin
		if (acc_in && s_tuser == CmdWeight && in_addr < ImgSize) wmem[in_addr] <= in_val;
		rdata_q <= wmem[raddr];
	end

	// push of one character into the context
	always_comb begin
		push_en = 1'b0;
		push_c  = 8'h3E;
		if (acc_in && s_tuser == CmdPrompt && in_val != 8'd0
			&& len_q < 9'(ContextLimit - 2)) begin
			push_en = 1'b1;
			push_c  = in_c;
		end else if (acc_in && s_tuser == CmdGen) begin
			push_en = 1'b1;
		end else if (state_q == S_DEC && best_idx_q != StopIdx
			&& (!pend_v_q || out_free) && len_q < 9'(ContextLimit - 1)) begin
			push_en = 1'b1;
			push_c  = dec_c;
		end
		tri_sum = {5'd0, p0_q[6:0]} * 12'd31 + {5'd0, p1_q[6:0]} * 12'd7 + {5'd0, push_c[6:0]};
	end

	always_comb begin
		sum1 = '0;
		for (int k = 0; k < 8; k++) begin
			if (rdata_q[k]) sum1 = sum1 + $signed({4'd0, feat_q[k]});
			else sum1 = sum1 - $signed({4'd0, feat_q[k]});
		end
		tot1 = acc1_q + 16'(sum1);
		if (tot1 < 0) hval = 8'd0;
		else if (tot1 > 16'sd255) hval = 8'hFF;
		else hval = tot1[7:0];

		sum2 = '0;
		for (int k = 0; k < 4; k++) begin
			case (rdata_q[2*k +: 2])
				2'd1: sum2 = sum2 - $signed({4'd0, hid_q[k]});
				2'd2: sum2 = sum2 + $signed({4'd0, hid_q[k]});
				2'd3: sum2 = sum2 - $signed({3'd0, hid_q[k], 1'b0});
				default: sum2 = sum2;
			endcase
		end
		tot2 = acc2_q + 18'(sum2);
		if (row_q[5:0] == StopIdx) begin
			if (prod_q < 4'd3) tot2 = tot2 - 18'sd40;
			else if (prod_q < 4'd8) tot2 = tot2 - 18'sd15;
		end
	end

	always_comb begin
		raddr = 11'd0;
		unique case (state_q)
			S_L1RB: raddr = B1Base + {4'd0, row_q};
			S_L1B:  raddr = {4'd0, row_q} * 11'd12;
			S_L1A:  raddr = {4'd0, row_q} * 11'd12 + {7'd0, col_q} + 11'd1;
			S_L2RB: raddr = B2Base + {4'd0, row_q};
			S_L2B:  raddr = L2Base + {row_q, 4'd0};
			S_L2A:  raddr = L2Base + {row_q, 4'd0} + {7'd0, col_q} + 11'd1;
			default: raddr = 11'd0;
		endcase

		fctl            = '0;
		fctl.shift      = (state_q == S_L1A);
		fctl.clear      = (state_q == S_FIN) && out_free;
		fctl.set_pos    = (state_q == S_INIT);
		fctl.pos_en     = (prod_q != 4'd0) && (gt_q || grew_q);
		fctl.pos_a      = 7'd80 + {4'd0, p1_q[2:0]};
		fctl.pos_b      = 7'd88 + {4'd0, prod_q[2:0]};
		fctl.bump_t_en  = push_en && len_q >= 9'd2;
		fctl.bump_t_idx = tri_sum[5:0];
		fctl.bump_c_en  = push_en;
		fctl.bump_c_idx = push_c[3:0];

		hctl.load = (state_q == S_L1A) && col_q == 4'd11;
		hctl.rot  = (state_q == S_L2A);
	end

	for (genvar i = 0; i < NumFeat; i++) begin : g_feat
		bmcg_feat_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cell_id (7'(i)),
			.nb      (feat_q[(i + 8) % NumFeat]),
			.ctl     (fctl),
			.q       (feat_q[i])
		);
	end

	for (genvar i = 0; i < NumHid; i++) begin : g_hid
		if (i == NumHid - 1) begin : g_tail
			bmcg_hid_cell u_cell (
				.clk (clk),
				.nb1 (hval),
				.nb4 (hid_q[(i + 4) % NumHid]),
				.ctl (hctl),
				.q   (hid_q[i])
			);
		end else begin : g_body
			bmcg_hid_cell u_cell (
				.clk (clk),
				.nb1 (hid_q[i + 1]),
				.nb4 (hid_q[(i + 4) % NumHid]),
				.ctl (hctl),
				.q   (hid_q[i])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_L1B) acc1_q <= 16'($signed(rdata_q));
		else if (state_q == S_L1A) acc1_q <= tot1;
		if (state_q == S_L2B) acc2_q <= 18'($signed(rdata_q));
		else if (state_q == S_L2A) acc2_q <= acc2_q + 18'(sum2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			prod_q      <= '0;
			grew_q      <= 1'b0;
			gt_q        <= 1'b0;
			pend_v_q    <= 1'b0;
			pend_q      <= '0;
			p0_q        <= '0;
			p1_q        <= '0;
			len_q       <= '0;
			best_q      <= '0;
			best_idx_q  <= '0;
			out_v_q     <= 1'b0;
			out_empty_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_char_q  <= '0;
		end else begin
			if (out_load) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
			if (push_en) begin
				p0_q  <= p1_q;
				p1_q  <= push_c;
				len_q <= len_q + 9'd1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc_in && s_tuser == CmdPrompt && push_en && in_c == 8'h3E) gt_q <= 1'b1;
					if (acc_in && s_tuser == CmdGen) begin
						prod_q   <= '0;
						grew_q   <= 1'b0;
						pend_v_q <= 1'b0;
						state_q  <= S_INIT;
					end
				end
				S_INIT: begin
					row_q   <= '0;
					state_q <= S_L1RB;
				end
				S_L1RB: state_q <= S_L1B;
				S_L1B: begin
					col_q   <= '0;
					state_q <= S_L1A;
				end
				S_L1A: begin
					col_q <= col_q + 4'd1;
					if (col_q == 4'd11) begin
						if (row_q == 7'(NumHid - 1)) begin
							row_q   <= '0;
							state_q <= S_L2RB;
						end else begin
							row_q   <= row_q + 7'd1;
							state_q <= S_L1RB;
						end
					end
				end
				S_L2RB: state_q <= S_L2B;
				S_L2B: begin
					col_q   <= '0;
					state_q <= S_L2A;
				end
				S_L2A: begin
					col_q <= col_q + 4'd1;
					if (col_q == 4'd15) begin
						if (row_q == 7'd0 || tot2 > best_q) begin
							best_q     <= tot2;
							best_idx_q <= row_q[5:0];
						end
						if (row_q == 7'(NumOut - 1)) begin
							state_q <= S_DEC;
						end else begin
							row_q   <= row_q + 7'd1;
							state_q <= S_L2RB;
						end
					end
				end
				S_DEC: begin
					if (best_idx_q == StopIdx) begin
						state_q <= S_FIN;
					end else if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_char_q  <= pend_q;
							out_empty_q <= 1'b0;
							out_last_q  <= 1'b0;
						end
						pend_q   <= dec_c;
						pend_v_q <= 1'b1;
						if (push_en) grew_q <= 1'b1;
						prod_q <= prod_q + 4'd1;
						if (prod_q == 4'(MaxGenerated - 1)) state_q <= S_FIN;
						else state_q <= S_INIT;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_char_q  <= pend_v_q ? pend_q : 8'd0;
						out_empty_q <= !pend_v_q;
						out_last_q  <= 1'b1;
						pend_v_q    <= 1'b0;
						p0_q        <= '0;
						p1_q        <= '0;
						len_q       <= '0;
						gt_q        <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* rtl/core/bmcg_feat_cell.sv */
// one byte of the feature chain: a saturating context count or a position flag
// depends on bmcg_pkg
module bmcg_feat_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [6:0]           cell_id,
	input  logic [7:0]           nb,
	input  bmcg_pkg::feat_ctl_t  ctl,
	output logic [7:0]           q
);
	import bmcg_pkg::*;

	logic hit;

	always_comb begin
		hit = (ctl.bump_t_en && cell_id == {1'b0, ctl.bump_t_idx})
			|| (ctl.bump_c_en && cell_id == (7'd64 + {3'b000, ctl.bump_c_idx}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= 8'd0;
		end else if (ctl.clear) begin
			q <= 8'd0;
		end else if (ctl.shift) begin
			q <= nb;
		end else if (ctl.set_pos) begin
			if (cell_id >= 7'd80)
				q <= (ctl.pos_en && (cell_id == ctl.pos_a || cell_id == ctl.pos_b)) ? 8'd1 : 8'd0;
		end else if (hit && q != 8'hFF) begin
			q <= q + 8'd1;
		end
	end
endmodule

/* rtl/core/bmcg_hid_cell.sv */
// one hidden activation in the hidden chain: shift-in on load, rotate by four for layer two
// depends on bmcg_pkg
module bmcg_hid_cell (
	input  logic                clk,
	input  logic [7:0]          nb1,
	input  logic [7:0]          nb4,
	input  bmcg_pkg::hid_ctl_t  ctl,
	output logic [7:0]          q
);
	import bmcg_pkg::*;

	always_ff @(posedge clk) begin
		if (ctl.load) q <= nb1;
		else if (ctl.rot) q <= nb4;
	end
endmodule

/* sim/bmcg_checker.sv */
`timescale 1ns / 100ps
// checker for the binary mlp character generator: watches both stream channels,
// predicts every generated word and compares it field by field; depends on bmcg_pkg
module bmcg_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // weight_addr, byte_value, zero fill
	input  logic [1:0]  s_tuser,   // cmd
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // out_char
	input  logic        m_tuser,   // is_empty
	input  logic        m_tlast,
	output int          pending,
	output int          failures,
	output int          produced
);
	import bmcg_pkg::*;

	typedef struct {
		logic [7:0] ch;
		logic       empty;
		logic       last;
	} gen_word_t;

	localparam string Alphabet = " abcdefghijklmnopqrstuvwxyz0123456789.-,!?'/";
	localparam int Int2Val [4] = '{0, -1, 1, -2};

	gen_word_t  gen_q [$];
	logic [7:0] wmem [0:ImgSize-1];
	logic [7:0] cnt [0:79];
	logic [7:0] prev0, prev1;
	int         ctx_len;
	bit         saw_gt;

	task automatic clear_ctx();
		for (int i = 0; i < 80; i++) cnt[i] = 8'd0;
		prev0   = 8'd0;
		prev1   = 8'd0;
		ctx_len = 0;
		saw_gt  = 1'b0;
	endtask

	task automatic bump(input int idx);
		if (cnt[idx] != 8'hFF) cnt[idx] = cnt[idx] + 8'd1;
	endtask

	task automatic add_char(input logic [7:0] c);
		int t;
		if (ctx_len >= 2) begin
			t = int'(prev0 & 8'h7F) * 31 + int'(prev1 & 8'h7F) * 7 + int'(c & 8'h7F);
			bump(t & 'h3F);
		end
		bump(64 + int'(c & 8'h0F));
		prev0 = prev1;
		prev1 = c;
		ctx_len++;
	endtask

	task automatic generate_text();
		int         feat [NumFeat];
		int         hid [NumHid];
		int         acc, best, bi, n;
		bit         grew;
		logic [7:0] w, ch;
		gen_word_t  gw;
		add_char(8'h3E);
		grew = 1'b0;
		n    = 0;
		for (int step = 0; step < MaxGenerated; step++) begin
			for (int i = 0; i < NumFeat; i++) feat[i] = (i < 80) ? int'(cnt[i]) : 0;
			if (step >= 1 && (saw_gt || grew)) begin
				feat[80 + int'(prev1 & 8'h07)] = 1;
				feat[88 + (step & 7)] = 1;
			end
			for (int r = 0; r < NumHid; r++) begin
				acc = int'($signed(wmem[B1Base + r]));
				for (int c = 0; c < NumFeat; c++) begin
					w = wmem[r * 12 + c / 8];
					acc += w[c % 8] ? feat[c] : -feat[c];
				end
				hid[r] = (acc < 0) ? 0 : ((acc > 255) ? 255 : acc);
			end
			best = 0;
			bi   = 0;
			for (int r = 0; r < NumOut; r++) begin
				acc = int'($signed(wmem[B2Base + r]));
				for (int c = 0; c < NumHid; c++) begin
					w = wmem[L2Base + r * 16 + c / 4];
					acc += Int2Val[(w >> ((c % 4) * 2)) & 8'h03] * hid[c];
				end
				if (r == StopIdx) begin
					if (step < 3) acc -= 40;
					else if (step < 8) acc -= 15;
				end
				if (r == 0 || acc > best) begin
					best = acc;
					bi   = r;
				end
			end
			if (bi == StopIdx) break;
			ch       = Alphabet[bi];
			gw.ch    = ch;
			gw.empty = 1'b0;
			gw.last  = 1'b0;
			gen_q.push_back(gw);
			n++;
			if (ctx_len < ContextLimit - 1) begin
				add_char(ch);
				grew = 1'b1;
			end
		end
		if (n == 0) begin
			gw.ch    = 8'd0;
			gw.empty = 1'b1;
			gw.last  = 1'b1;
			gen_q.push_back(gw);
			n = 1;
		end else begin
			gen_q[gen_q.size() - 1].last = 1'b1;
		end
		produced += n;
		clear_ctx();
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [10:0] addr;
		logic [7:0]  val;
		gen_word_t   gw;
		if (!arst_n) begin
			gen_q.delete();
			clear_ctx();
			failures = 0;
			produced = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (gen_q.size() == 0) begin
					$display("%0t: unexpected word char %h empty %b last %b",
						$time, m_tdata, m_tuser, m_tlast);
					failures++;
				end else begin
					gw = gen_q.pop_front();
					if (gw.ch !== m_tdata || gw.empty !== m_tuser || gw.last !== m_tlast) begin
						$display("%0t: expected char %h empty %b last %b, got %h %b %b",
							$time, gw.ch, gw.empty, gw.last, m_tdata, m_tuser, m_tlast);
						failures++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				addr = s_tdata[10:0];
				val  = s_tdata[18:11];
				case (s_tuser)
					CmdWeight: begin
						if (addr < ImgSize) wmem[addr] = val;
					end
					CmdPrompt: begin
						if (val != 8'd0 && ctx_len < ContextLimit - 2) begin
							if (val >= 8'h41 && val <= 8'h5A) val = val + 8'd32;
							if (val == 8'h3E) saw_gt = 1'b1;
							add_char(val);
						end
					end
					CmdGen: generate_text();
					default: ;
				endcase
			end
		end
		pending = gen_q.size();
	end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// testbench top for the binary mlp character generator: weight images, prompts and
// generate words under varying idle and stall; depends on bmcg_pkg, bmcg_checker and the core
module tb_top;
	import bmcg_pkg::*;

	localparam int QuietLimit = 100000;
	localparam string PromptPool =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ 0123456789>.,!?";

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = 24'd0;   // weight_addr, byte_value, zero fill
	logic [1:0]  s_tuser = 2'd0;    // cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;           // out_char
	logic        m_tuser;           // is_empty
	logic        m_tlast;
	logic        s_fire = 1'b0;
	int          pending, failures, produced;
	int          idle_pct = 0, stall_pct = 0, quiet = 0, items = 0, gens = 0;

	binary_mlp_char_generator_core u_top (.*);

	bmcg_checker u_checker (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		s_fire <= s_tvalid && s_tready;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= QuietLimit) begin
			$display("tb_top failed");
			$finish;
		end
	end

	always @(negedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

	task automatic send_word(input logic [1:0] cmd, input logic [10:0] addr,
		input logic [7:0] val);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {5'd0, val, addr};
		do @(negedge clk); while (!s_fire);
	endtask

	task automatic prompt_char(input logic [7:0] c);
		send_word(CmdPrompt, 11'($urandom_range(2047)), c);
		items++;
	endtask

	task automatic gen_word();
		send_word(CmdGen, 11'($urandom_range(2047)), 8'($urandom_range(255)));
		items++;
		gens++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	// flat images zero the second layer so the output biases alone pick the character
	task automatic load_image(input bit flat, input int fav, input logic [7:0] stop_bias);
		logic [7:0] v;
		drain();
		for (int a = 0; a < ImgSize; a++) begin
			v = 8'($urandom_range(255));
			if (a >= L2Base && a < B1Base && flat) v = 8'd0;
			if (a >= B2Base) begin
				if (flat) v = (a - B2Base == fav) ? 8'h7F : 8'h80;
				else if (a - B2Base == StopIdx) v = stop_bias;
			end
			send_word(CmdWeight, 11'(a), v);
		end
	endtask

	task automatic set_phase(input int ph);
		case (ph % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 67; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 67; end
			default: begin idle_pct = 29; stall_pct = 29; end
		endcase
	endtask

	initial begin
		int len, r;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty generation, ignored words and case folding
		load_image(1'b1, StopIdx, 8'h00);
		send_word(2'd3, 11'h7FF, 8'hFF);
		send_word(CmdWeight, ImgSize, 8'h55);
		send_word(CmdWeight, 11'h7FF, 8'hAA);
		prompt_char(8'h00);
		prompt_char("A");
		prompt_char("Z");
		prompt_char("a");
		prompt_char("z");
		prompt_char(">");
		prompt_char(8'hFF);
		prompt_char(8'h80);
		gen_word();

		// fifteen words from an empty prompt
		load_image(1'b1, 5, 8'h00);
		gen_word();
		set_phase(3);
		prompt_char("x");
		gen_word();

		load_image(1'b0, 0, 8'h80);
		prompt_char("H");
		prompt_char("i");
		prompt_char(">");
		gen_word();
		prompt_char("q");
		gen_word();

		for (int sq = 0; (items < 290 || produced < 48) && gens < 16; sq++) begin
			if (sq % 3 == 0) load_image(1'b0, 0, 8'($urandom_range(255)));
			set_phase(sq);
			len = (sq == 2) ? $urandom_range(258, 250) : $urandom_range(30, 1);
			for (int i = 0; i < len; i++) begin
				r = $urandom_range(99);
				if (r < 2) send_word(2'd3, 11'($urandom_range(2047)), 8'($urandom_range(255)));
				else if (r < 4) send_word(CmdWeight, 11'($urandom_range(2047, ImgSize)),
					8'($urandom_range(255)));
				else if (r < 6) prompt_char(8'h00);
				else if (r < 7) send_word(CmdWeight, 11'($urandom_range(ImgSize - 1)),
					8'($urandom_range(255)));
				else if (r < 12) prompt_char(8'($urandom_range(255)));
				else prompt_char(PromptPool[$urandom_range(PromptPool.len() - 1)]);
			end
			if (sq == 1) begin
				drain();
			end
			gen_word();
		end

		drain();
		repeat (200) @(negedge clk);
		if (failures == 0 && pending == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
